FILE: rtl/rglf_pkg.sv
// Shared types, constants and fixed-point helpers of the recursive Gaussian line filter.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package rglf_pkg;
	localparam int ROW_MAX    = 64;
	localparam int ADDR_W     = $clog2(ROW_MAX);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int PIXEL_BITS = 16;
	localparam int FRAC_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;
	localparam int FIELD_W    = 20;
	localparam int COEF_W     = 22;
	localparam int OPND_W     = 33;
	localparam int PROD_W     = COEF_W + OPND_W;
	localparam int ACC_W      = 60;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = FIFO_AW + 1;
	localparam int PIX_MAX    = (1 << PIXEL_BITS) - 1;
	localparam int ONE_Q16    = 65536;

	localparam logic [1:0] MODE_BYPASS = 2'd0;
	localparam logic [1:0] MODE_TAP    = 2'd1;
	localparam logic [1:0] MODE_REC    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FB    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BROW0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BROW1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BROW2 = 3'd5;

	typedef struct packed {
		logic [15:0] sample;
		logic        row_end;
	} pixel_t;

	typedef struct packed {
		logic [15:0] filtered;
		logic        last_of_row;
		logic        row_overflowed;
	} result_t;

	typedef struct packed {
		logic [1:0]            filter_mode;
		logic [14:0]           side_tap;
		logic [CFG_DATA_W-1:0] feedback_coeffs;
		logic [CFG_DATA_W-1:0] boundary_row_zero;
		logic [CFG_DATA_W-1:0] boundary_row_one;
		logic [CFG_DATA_W-1:0] boundary_row_two;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       data;
	} smp_wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic             ovf;
	} job_t;

	function automatic logic signed [COEF_W-1:0] coef_field(input logic [CFG_DATA_W-1:0] v,
			input int k);
		return COEF_W'($signed(v[FIELD_W*k +: FIELD_W]));
	endfunction

	function automatic logic [PIXEL_BITS-1:0] clamp_pix(input logic signed [ACC_W-1:0] w);
		logic [PIXEL_BITS-1:0] p;
		if (w < 0)
			p = '0;
		else if (w > ACC_W'(PIX_MAX))
			p = PIXEL_BITS'(PIX_MAX);
		else
			p = w[PIXEL_BITS-1:0];
		return p;
	endfunction

	// (acc + 2^15) >> 16 with floor, saturated to the signed 32-bit range
	function automatic logic signed [31:0] sat_round(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		logic signed [31:0]      r;
		t = (acc + ACC_W'(32768)) >>> 16;
		if (t > $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF}))
			r = 32'sh7FFF_FFFF;
		else if (t < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000}))
			r = 32'sh8000_0000;
		else
			r = t[31:0];
		return r;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] tap_pix(input logic signed [ACC_W-1:0] acc);
		return clamp_pix((acc + ACC_W'(32768)) >>> 16);
	endfunction

	function automatic logic [PIXEL_BITS-1:0] int_to_pix(input logic signed [31:0] v);
		return clamp_pix((ACC_W'(v) + ACC_W'(1 << (FRAC_W - 1))) >>> FRAC_W);
	endfunction
endpackage

FILE: rtl/recursive_gaussian_line_filter.sv
// Recursive mode filters rows of n >= 4 pixels, three-tap mode rows of n >= 3; others
// pass through. Results are then issued one per cycle while the result queue has room.
// Throughput: one pixel per cycle while a row arrives; the shared multiply-accumulate
// unit serves each pixel in turn in every recursive pass. push is refused from row_end
// until the row's last result is issued to the result queue. Reset (arst_n low): control
// registers, counts and queues clear; data registers and row stores are not cleared.
`timescale 1ns / 1ps
module recursive_gaussian_line_filter import rglf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pixel_t                pixel,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t             cfg_q;
	smp_wr_t          smp_wr;
	job_t             job;
	logic             job_valid, job_take, back_busy;
	logic             res_push;
	result_t          res_data;
	logic [LVL_W-1:0] res_level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:  cfg_q.filter_mode       <= cfg_data[1:0];
				REG_SIDE:  cfg_q.side_tap          <= cfg_data[14:0];
				REG_FB:    cfg_q.feedback_coeffs   <= cfg_data;
				REG_BROW0: cfg_q.boundary_row_zero <= cfg_data;
				REG_BROW1: cfg_q.boundary_row_one  <= cfg_data;
				REG_BROW2: cfg_q.boundary_row_two  <= cfg_data;
				default: ;
			endcase
		end
	end

	rglf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.back_busy (back_busy),
		.job_take  (job_take),
		.job_valid (job_valid),
		.job       (job),
		.smp_wr    (smp_wr)
	);

	rglf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.smp_wr    (smp_wr),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.busy      (back_busy),
		.res_level (res_level),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	rglf_res_fifo u_res (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.pop     (pop),
		.empty   (empty),
		.head    (result),
		.level   (res_level)
	);
endmodule

FILE: rtl/rglf_front.sv
// Front end: takes pixels, writes them to the row store, counts and flags overflow.
// Hands a finished row to the back end through a one-slot job queue. Uses rglf_pkg.
`timescale 1ns / 1ps
module rglf_front import rglf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  pixel_t  pixel,
	output logic    full,
	input  logic    back_busy,
	input  logic    job_take,
	output logic    job_valid,
	output job_t    job,
	output smp_wr_t smp_wr
);
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             job_valid_q;
	job_t             job_q;
	logic             accept;
	logic             room;

	assign full      = job_valid_q | back_busy;
	assign accept    = push & ~full;
	assign room      = cnt_q < CNT_W'(ROW_MAX);
	assign job_valid = job_valid_q;
	assign job       = job_q;

	assign smp_wr.en   = accept & room;
	assign smp_wr.addr = cnt_q[ADDR_W-1:0];
	assign smp_wr.data = pixel.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			job_valid_q <= 1'b0;
		end else begin
			if (job_take)
				job_valid_q <= 1'b0;
			if (accept) begin
				if (pixel.row_end) begin
					job_valid_q <= 1'b1;
					cnt_q       <= '0;
					ovf_q       <= 1'b0;
				end else if (room) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pixel.row_end) begin
			job_q.n   <= room ? cnt_q + 1'b1 : cnt_q;
			job_q.ovf <= ovf_q | ~room;
		end
	end
endmodule

FILE: rtl/rglf_res_fifo.sv
// Result queue between the back end and the result ports.
// Uses rglf_pkg for the result type and depth.
`timescale 1ns / 1ps
module rglf_res_fifo import rglf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  result_t          wr_data,
	input  logic             pop,
	output logic             empty,
	output result_t          head,
	output logic [LVL_W-1:0] level
);
	result_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [LVL_W-1:0]   cnt_q;
	logic               rd_en;

	assign empty = cnt_q == '0;
	assign head  = mem_q[rp_q];
	assign level = cnt_q;
	assign rd_en = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= wp_q + 1'b1;
			if (rd_en)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + LVL_W'(wr_en) - LVL_W'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_data;
	end
endmodule

FILE: rtl/rglf_back.sv
// Back end: row stores, shared multiply-accumulate sequencer for the causal pass,
// boundary values, anticausal pass and three-tap kernel, then ordered emission. Uses rglf_pkg.
`timescale 1ns / 1ps
module rglf_back import rglf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  smp_wr_t          smp_wr,
	input  logic             job_valid,
	input  job_t             job,
	output logic             job_take,
	output logic             busy,
	input  logic [LVL_W-1:0] res_level,
	output logic             res_push,
	output result_t          res_data
);
	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_RD   = 6'b000010,
		B_LOAD = 6'b000100,
		B_MAC  = 6'b001000,
		B_WB   = 6'b010000,
		B_EMIT = 6'b100000
	} bstate_t;

	typedef enum logic [3:0] {
		PH_FWD = 4'b0001,
		PH_BND = 4'b0010,
		PH_BWD = 4'b0100,
		PH_TAP = 4'b1000
	} phase_t;

	logic [15:0] smem [ROW_MAX];
	logic [31:0] rmem [ROW_MAX];
	logic [15:0] s_rd_q;
	logic [31:0] r_rd_q;

	bstate_t                  st_q;
	phase_t                   ph_q;
	logic [ADDR_W-1:0]        j_q;
	logic [CNT_W-1:0]         n_q;
	logic                     ovf_q;
	logic                     use_rec_q;
	logic                     use_tap_q;
	logic [2:0]               tc_q;
	logic [1:0]               k_q;
	logic signed [OPND_W-1:0] xq;
	logic signed [31:0]       p1_q, p2_q, p3_q;
	logic signed [31:0]       bv_q [3];
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     e_v_s1, e_last_s1, e_rec_s1;

	logic signed [COEF_W-1:0] b1, b2, b3, g, c1, c0, coef;
	logic signed [OPND_W-1:0] opnd;
	logic [CFG_DATA_W-1:0]    brow;
	logic [2:0]               nterm;
	logic signed [31:0]       r_new;
	logic                     at_last;
	logic                     issue;
	logic                     rw_en;
	logic [ADDR_W-1:0]        rw_addr;
	logic [31:0]              rw_data;

	assign b1 = coef_field(cfg.feedback_coeffs, 0);
	assign b2 = coef_field(cfg.feedback_coeffs, 1);
	assign b3 = coef_field(cfg.feedback_coeffs, 2);
	assign g  = COEF_W'(ONE_Q16) - b1 - b2 - b3;
	assign c1 = $signed({{(COEF_W-15){1'b0}}, cfg.side_tap});
	assign c0 = COEF_W'(ONE_Q16) - (c1 <<< 1);

	assign nterm    = (ph_q == PH_TAP) ? 3'd3 : 3'd4;
	assign r_new    = sat_round(acc_q);
	assign at_last  = {1'b0, j_q} == n_q - 1'b1;
	assign busy     = st_q != B_IDLE;
	assign job_take = (st_q == B_IDLE) & job_valid;
	assign issue    = (st_q == B_EMIT) &&
		((res_level + LVL_W'(e_v_s1)) < LVL_W'(FIFO_DEPTH));

	always_comb begin
		case (k_q)
			2'd0:    brow = cfg.boundary_row_zero;
			2'd1:    brow = cfg.boundary_row_one;
			default: brow = cfg.boundary_row_two;
		endcase
	end

	always_comb begin
		coef = g;
		opnd = xq;
		case (ph_q)
			PH_TAP: begin
				case (tc_q)
					3'd0: begin
						coef = c1;
						opnd = OPND_W'(p3_q);
					end
					3'd1: begin
						coef = c1;
						opnd = OPND_W'(p1_q);
					end
					default: begin
						coef = c0;
						opnd = OPND_W'(p2_q);
					end
				endcase
			end
			PH_BND: begin
				case (tc_q)
					3'd0: begin
						coef = COEF_W'(ONE_Q16);
						opnd = xq;
					end
					3'd1: begin
						coef = coef_field(brow, 0);
						opnd = OPND_W'(p1_q) - xq;
					end
					3'd2: begin
						coef = coef_field(brow, 1);
						opnd = OPND_W'(p2_q) - xq;
					end
					default: begin
						coef = coef_field(brow, 2);
						opnd = OPND_W'(p3_q) - xq;
					end
				endcase
			end
			default: begin
				case (tc_q)
					3'd0: begin
						coef = g;
						opnd = xq;
					end
					3'd1: begin
						coef = b1;
						opnd = OPND_W'(p1_q);
					end
					3'd2: begin
						coef = b2;
						opnd = OPND_W'(p2_q);
					end
					default: begin
						coef = b3;
						opnd = OPND_W'(p3_q);
					end
				endcase
			end
		endcase
	end

	// recursion store write port, used only at write-back
	always_comb begin
		rw_en   = st_q == B_WB;
		rw_addr = j_q;
		rw_data = r_new;
		case (ph_q)
			PH_BND: begin
				rw_en   = (st_q == B_WB) && (k_q == 2'd2);
				rw_addr = ADDR_W'(n_q - 1'b1);
				rw_data = 32'(int_to_pix(bv_q[0]));
			end
			PH_BWD:  rw_data = 32'(int_to_pix(r_new));
			PH_TAP: begin
				rw_addr = j_q - 1'b1;
				rw_data = 32'(tap_pix(acc_q));
			end
			default: rw_data = r_new;
		endcase
	end

	always_ff @(posedge clk) begin
		if (smp_wr.en)
			smem[smp_wr.addr] <= smp_wr.data;
		s_rd_q <= smem[j_q];
		if (rw_en)
			rmem[rw_addr] <= rw_data;
		r_rd_q <= rmem[j_q];
	end

	always_ff @(posedge clk) begin
		if (st_q == B_MAC) begin
			prod_s1 <= coef * opnd;
			if (tc_q == 3'd0)
				acc_q <= '0;
			else
				acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (st_q == B_LOAD) begin
			if (ph_q == PH_FWD) begin
				xq <= OPND_W'({s_rd_q, {FRAC_W{1'b0}}});
				if (j_q == '0) begin
					p1_q <= 32'({s_rd_q, {FRAC_W{1'b0}}});
					p2_q <= 32'({s_rd_q, {FRAC_W{1'b0}}});
					p3_q <= 32'({s_rd_q, {FRAC_W{1'b0}}});
				end
			end else if (ph_q == PH_BWD) begin
				xq <= OPND_W'($signed(r_rd_q));
			end else begin
				p3_q <= p2_q;
				p2_q <= p1_q;
				p1_q <= 32'(s_rd_q);
			end
		end
		if (st_q == B_WB) begin
			if (ph_q == PH_BND) begin
				bv_q[k_q] <= r_new;
				if (k_q == 2'd2) begin
					p1_q <= bv_q[0];
					p2_q <= bv_q[1];
					p3_q <= r_new;
				end
			end else if (ph_q != PH_TAP) begin
				p3_q <= p2_q;
				p2_q <= p1_q;
				p1_q <= r_new;
			end
		end
		if (issue) begin
			e_last_s1 <= at_last;
			e_rec_s1  <= use_rec_q | (use_tap_q & (j_q != '0) & ~at_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			ph_q      <= PH_FWD;
			j_q       <= '0;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			use_rec_q <= 1'b0;
			use_tap_q <= 1'b0;
			tc_q      <= '0;
			k_q       <= '0;
			e_v_s1    <= 1'b0;
		end else begin
			e_v_s1 <= issue;
			case (st_q)
				B_IDLE: begin
					if (job_valid) begin
						n_q       <= job.n;
						ovf_q     <= job.ovf;
						j_q       <= '0;
						use_rec_q <= 1'b0;
						use_tap_q <= 1'b0;
						if (cfg.filter_mode == MODE_REC && job.n >= CNT_W'(4)) begin
							use_rec_q <= 1'b1;
							ph_q      <= PH_FWD;
							st_q      <= B_RD;
						end else if (cfg.filter_mode == MODE_TAP && job.n >= CNT_W'(3)) begin
							use_tap_q <= 1'b1;
							ph_q      <= PH_TAP;
							st_q      <= B_RD;
						end else begin
							st_q <= B_EMIT;
						end
					end
				end
				B_RD: st_q <= B_LOAD;
				B_LOAD: begin
					// the kernel preloads two samples before its first tap
					if (ph_q == PH_TAP && j_q < ADDR_W'(2)) begin
						j_q  <= j_q + 1'b1;
						st_q <= B_RD;
					end else begin
						tc_q <= '0;
						st_q <= B_MAC;
					end
				end
				B_MAC: begin
					if (tc_q == nterm)
						st_q <= B_WB;
					else
						tc_q <= tc_q + 1'b1;
				end
				B_WB: begin
					tc_q <= '0;
					case (ph_q)
						PH_FWD: begin
							if (at_last) begin
								ph_q <= PH_BND;
								k_q  <= '0;
								st_q <= B_MAC;
							end else begin
								j_q  <= j_q + 1'b1;
								st_q <= B_RD;
							end
						end
						PH_BND: begin
							if (k_q == 2'd2) begin
								ph_q <= PH_BWD;
								j_q  <= ADDR_W'(n_q - CNT_W'(2));
								st_q <= B_RD;
							end else begin
								k_q  <= k_q + 1'b1;
								st_q <= B_MAC;
							end
						end
						PH_BWD: begin
							if (j_q == '0) begin
								st_q <= B_EMIT;
							end else begin
								j_q  <= j_q - 1'b1;
								st_q <= B_RD;
							end
						end
						default: begin
							if (at_last) begin
								j_q  <= '0;
								st_q <= B_EMIT;
							end else begin
								j_q  <= j_q + 1'b1;
								st_q <= B_RD;
							end
						end
					endcase
				end
				B_EMIT: begin
					if (issue) begin
						if (at_last)
							st_q <= B_IDLE;
						else
							j_q <= j_q + 1'b1;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign res_push                = e_v_s1;
	assign res_data.filtered       = e_rec_s1 ? r_rd_q[15:0] : s_rd_q;
	assign res_data.last_of_row    = e_last_s1;
	assign res_data.row_overflowed = ovf_q;
endmodule

FILE: rtl/rglf_checker.sv
// Port-level checks of the recursive Gaussian line filter, bound to the top level.
// Uses rglf_pkg for the port types.
`timescale 1ns / 1ps
module rglf_checker import rglf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input pixel_t                pixel,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input result_t               result,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);
	// an accepted row end must be followed by full high, closing the input
	a_row_closes: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && pixel.row_end |=> full)
		else $error("input still open after row end");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

	a_ovf_per_row: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !result.last_of_row |=> empty ||
			result.row_overflowed == $past(result.row_overflowed))
		else $error("overflow flag changed inside a row");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");
endmodule

bind recursive_gaussian_line_filter rglf_checker u_chk (.*);
